// ===== sv/ccv_pkg.sv =====
// shared types and constants of the csv column count validator
// used by the front classifier, the token queue and the line checker
`default_nettype none

package ccv_pkg;

	// byte codes the classifier looks for
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// depth of the queue between classifier and checker
	localparam int unsigned QDEPTH = 4;

	// byte classes seen by the checker
	typedef enum logic [2:0] {
		CL_OTHER,
		CL_COMMA,
		CL_LF,
		CL_CR,
		CL_BLANK,
		CL_NUL
	} cls_t;

	// one classified byte
	typedef struct packed {
		cls_t cls;
		logic eof;
	} tok_t;

	// line position of the checker
	typedef enum logic [1:0] {
		PH_START,
		PH_IN_LINE,
		PH_AFTER_CR
	} phase_t;

	// result codes
	typedef enum logic [1:0] {
		ST_VALID,
		ST_NUL,
		ST_MISMATCH
	} status_t;

endpackage

`default_nettype wire

// ===== sv/ccv_front.sv =====
// front end: takes bytes from the input stream and classifies them
// depends on ccv_pkg; feeds ccv_queue
`default_nettype none

module ccv_front
	import ccv_pkg::*;
(
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // data_byte
	input  wire logic       s_tlast,   // end_of_file
	input  wire logic       q_full,
	output logic            push,
	output tok_t            push_tok
);

	// accept whenever the queue has room
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// byte classification
	always_comb begin
		priority if (s_tdata == CH_COMMA) begin
			push_tok.cls = CL_COMMA;
		end else if (s_tdata == CH_LF) begin
			push_tok.cls = CL_LF;
		end else if (s_tdata == CH_CR) begin
			push_tok.cls = CL_CR;
		end else if (s_tdata == CH_SPACE || s_tdata == CH_TAB) begin
			push_tok.cls = CL_BLANK;
		end else if (s_tdata == CH_NUL) begin
			push_tok.cls = CL_NUL;
		end else begin
			push_tok.cls = CL_OTHER;
		end
		push_tok.eof = s_tlast;
	end

endmodule

`default_nettype wire

// ===== sv/ccv_queue.sv =====
// short token queue between the classifier and the line checker
// depends on ccv_pkg for the token type
`default_nettype none

module ccv_queue
	import ccv_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  tok_t      push_tok,
	output logic      full,
	input  wire logic pop,
	output logic      tok_valid,
	output tok_t      tok
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	tok_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign tok_valid = (count_q != '0);
	assign tok       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/ccv_back.sv =====
// back end: walks the classified bytes, counts fields per line and latches
// the first error; holds the result register. depends on ccv_pkg
`default_nettype none

module ccv_back
	import ccv_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 1024,
	parameter int unsigned FW         = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tok_valid,
	input  tok_t               tok,
	output logic               pop,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [1:0]         res_status,
	output logic [31:0]        res_line,
	output logic [FW-1:0]      res_expected,
	output logic [FW-1:0]      res_found
);

	// line state
	phase_t        ph_q, ph_d;
	logic [FW-1:0] tot_q, tot_d;
	logic [FW-1:0] ref_q, ref_d;
	logic          await_q, await_d;
	logic          cont_q, cont_d;
	logic          pc_q, pc_d;
	logic [31:0]   lc_q, lc_d;
	status_t       st_q, st_d;
	logic [31:0]   lline_q, lline_d;
	logic [FW-1:0] lfound_q, lfound_d;
	logic          skip;

	// result register
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [31:0]   out_line_q;
	logic [FW-1:0] out_exp_q;
	logic [FW-1:0] out_found_q;

	function automatic logic [FW-1:0] sat_inc(input logic [FW-1:0] v);
		sat_inc = (v < FW'(MAX_FIELDS)) ? v + 1'b1 : v;
	endfunction

	// an end-of-file byte waits for a free result slot, others always go
	assign pop = tok_valid && (!tok.eof || !out_valid_q || m_tready);

	// next line state
	always_comb begin
		ph_d     = ph_q;
		tot_d    = tot_q;
		ref_d    = ref_q;
		await_d  = await_q;
		cont_d   = cont_q;
		pc_d     = pc_q;
		lc_d     = lc_q;
		st_d     = st_q;
		lline_d  = lline_q;
		lfound_d = lfound_q;
		skip     = 1'b0;
		if (st_q == ST_VALID) begin
			// lf right after a closing cr is swallowed
			if (ph_q == PH_AFTER_CR) begin
				ph_d = PH_START;
				if (tok.cls == CL_LF) begin
					skip = 1'b1;
				end
			end
			// leading whitespace and blank lines
			if (!skip && ph_d != PH_IN_LINE) begin
				if (tok.cls == CL_BLANK || tok.cls == CL_CR) begin
					skip = 1'b1;
				end else if (tok.cls == CL_LF) begin
					lc_d = lc_q + 1'b1;
					skip = 1'b1;
				end else begin
					ph_d   = PH_IN_LINE;
					tot_d  = '0;
					cont_d = 1'b0;
					pc_d   = 1'b0;
				end
			end
			// byte inside a line
			if (!skip) begin
				unique case (tok.cls)
					CL_COMMA: begin
						tot_d  = sat_inc(tot_d);
						cont_d = 1'b0;
						pc_d   = 1'b1;
					end
					CL_LF, CL_CR: begin
						tot_d  = sat_inc(tot_d);
						cont_d = 1'b0;
						pc_d   = 1'b0;
						lc_d   = lc_q + 1'b1;
						ph_d   = (tok.cls == CL_CR) ? PH_AFTER_CR : PH_START;
						if (await_d) begin
							ref_d   = tot_d;
							await_d = 1'b0;
						end else if (tot_d != ref_d) begin
							st_d     = ST_MISMATCH;
							lline_d  = lc_d;
							lfound_d = tot_d;
						end
					end
					CL_NUL: begin
						st_d    = ST_NUL;
						lline_d = lc_d;
					end
					default: begin
						cont_d = 1'b1;
						pc_d   = 1'b0;
					end
				endcase
			end
			// unterminated last line
			if (tok.eof && st_d == ST_VALID && ph_d == PH_IN_LINE) begin
				if (cont_d || pc_d) begin
					tot_d = sat_inc(tot_d);
				end
				if (await_d) begin
					ref_d   = tot_d;
					await_d = 1'b0;
				end else if (tot_d != ref_d) begin
					st_d     = ST_MISMATCH;
					lline_d  = lc_d;
					lfound_d = tot_d;
				end
			end
		end
	end

	// line state registers, cleared again after each file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_START;
			tot_q    <= '0;
			ref_q    <= '0;
			await_q  <= 1'b1;
			cont_q   <= 1'b0;
			pc_q     <= 1'b0;
			lc_q     <= '0;
			st_q     <= ST_VALID;
			lline_q  <= '0;
			lfound_q <= '0;
		end else if (pop) begin
			if (tok.eof) begin
				ph_q     <= PH_START;
				tot_q    <= '0;
				ref_q    <= '0;
				await_q  <= 1'b1;
				cont_q   <= 1'b0;
				pc_q     <= 1'b0;
				lc_q     <= '0;
				st_q     <= ST_VALID;
				lline_q  <= '0;
				lfound_q <= '0;
			end else begin
				ph_q     <= ph_d;
				tot_q    <= tot_d;
				ref_q    <= ref_d;
				await_q  <= await_d;
				cont_q   <= cont_d;
				pc_q     <= pc_d;
				lc_q     <= lc_d;
				st_q     <= st_d;
				lline_q  <= lline_d;
				lfound_q <= lfound_d;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && tok.eof) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && tok.eof) begin
			out_status_q <= st_d;
			out_line_q   <= (st_d != ST_VALID) ? lline_d : '0;
			out_exp_q    <= ref_d;
			out_found_q  <= (st_d == ST_MISMATCH) ? lfound_d : '0;
		end
	end

	// outputs
	always_comb begin
		m_tvalid     = out_valid_q;
		res_status   = out_status_q;
		res_line     = out_line_q;
		res_expected = out_exp_q;
		res_found    = out_found_q;
	end

endmodule

`default_nettype wire

// ===== sv/csv_column_count_validator_top.sv =====
// top level of the csv column count validator
// depends on ccv_pkg, ccv_front, ccv_queue and ccv_back
`default_nettype none

// Checks that every non-blank line of a CSV file has as many fields as the
// first one. Bytes enter on the s_ stream, one per cycle, with tlast on the
// final byte of a file; exactly one result request leaves on the m_ stream
// for each file, once its final byte has passed through the token queue
// and been registered in the result register. A classifier stage feeds
// a four-entry token queue and the line checker retires one byte per cycle,
// so the sustained rate is one byte per clock. Only an end-of-file byte can
// stall, when the previous result still sits unread in the output register;
// the queue then absorbs up to three more bytes before s_tready drops.
// Field counts saturate at MAX_FIELDS, and all state clears after each file.

module csv_column_count_validator_top
	import ccv_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 1024,
	parameter int unsigned FW         = $clog2(MAX_FIELDS + 1),
	parameter int unsigned DW         = ((2 + 32 + 2 * FW + 7) / 8) * 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,   // data_byte
	input  wire logic          s_tlast,   // end_of_file
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [DW-1:0]      m_tdata    // status, error_line, expected_fields, found_fields
);

	logic          q_full;
	logic          push;
	tok_t          push_tok;
	logic          pop;
	logic          tok_valid;
	tok_t          tok;
	logic [1:0]    res_status;
	logic [31:0]   res_line;
	logic [FW-1:0] res_expected;
	logic [FW-1:0] res_found;

	ccv_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_tok (push_tok)
	);

	ccv_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.full      (q_full),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok       (tok)
	);

	ccv_back #(
		.MAX_FIELDS (MAX_FIELDS),
		.FW         (FW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (tok_valid),
		.tok          (tok),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.res_status   (res_status),
		.res_line     (res_line),
		.res_expected (res_expected),
		.res_found    (res_found)
	);

	// pack result fields, lowest first
	always_comb begin
		m_tdata                     = '0;
		m_tdata[1:0]                = res_status;
		m_tdata[33:2]               = res_line;
		m_tdata[34 +: FW]           = res_expected;
		m_tdata[34 + FW +: FW]      = res_found;
	end

endmodule

`default_nettype wire

// ===== sv/ccv_checker.sv =====
// port-level checks for the csv column count validator
// depends on ccv_pkg; bound to csv_column_count_validator_top below
`default_nettype none

module ccv_checker
	import ccv_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 1024,
	parameter int unsigned FW         = $clog2(MAX_FIELDS + 1),
	parameter int unsigned DW         = ((2 + 32 + 2 * FW + 7) / 8) * 8
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          m_tvalid,
	input wire logic          m_tready,
	input wire logic [DW-1:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// status code is always a defined one
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == ST_VALID || m_tdata[1:0] == ST_NUL ||
			m_tdata[1:0] == ST_MISMATCH))
		else $error("undefined status code");

	// a clean file reports no error line
	a_clean_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ST_VALID |-> m_tdata[33:2] == '0)
		else $error("error line set on a clean file");

	// found count only on a mismatch, and neither count past the limit
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == ST_MISMATCH || m_tdata[34 + FW +: FW] == '0) &&
			m_tdata[34 + FW +: FW] <= FW'(MAX_FIELDS) &&
			m_tdata[34 +: FW] <= FW'(MAX_FIELDS))
		else $error("field count out of place or over limit");

endmodule

bind csv_column_count_validator_top ccv_checker #(
	.MAX_FIELDS (MAX_FIELDS),
	.FW         (FW),
	.DW         (DW)
) u_ccv_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench of csv_column_count_validator_top: byte requests in, one verdict per file out
// depends on ccv_pkg for byte codes and status codes; predicts each verdict on its own
module tb_top;
	import ccv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FIELD_CAP = 1024;
	localparam int unsigned FW        = 11;
	localparam int unsigned DW        = 56;
	localparam int          STALL_MAX = 2000;
	localparam int          DRAIN     = 50;
	localparam int          RAND_BYTES = 900;

	// one expected verdict
	typedef struct {
		status_t         st;
		logic [31:0]     line;
		logic [FW-1:0]   exp_fields;
		logic [FW-1:0]   found;
	} verdict_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [7:0]    s_tdata;   // data_byte
	logic          s_tlast;   // end_of_file
	logic          m_tvalid;
	logic          m_tready;
	logic [DW-1:0] m_tdata;   // status, error_line, expected_fields, found_fields

	verdict_t   verdict_q[$];
	logic [7:0] csv_buf[$];
	int         errors;
	int         idle_cycles;
	int         bytes_sent;
	bit         tx_calm;
	bit         rx_calm;

	// shadow of the line checker
	phase_t        ph;
	logic [FW-1:0] fcount;
	logic [FW-1:0] ref_fields;
	bit            first_pending;
	bit            has_content;
	bit            last_comma;
	logic [31:0]   line_no;
	status_t       err_st;
	logic [31:0]   err_line;
	logic [FW-1:0] err_found;

	csv_column_count_validator_top #(
		.MAX_FIELDS(FIELD_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_shadow();
		ph            = PH_START;
		fcount        = '0;
		ref_fields    = '0;
		first_pending = 1'b1;
		has_content   = 1'b0;
		last_comma    = 1'b0;
		line_no       = '0;
		err_st        = ST_VALID;
		err_line      = '0;
		err_found     = '0;
	endfunction

	function automatic void bump_field();
		if (fcount < FIELD_CAP)
			fcount = fcount + 1'b1;
	endfunction

	// first closed line sets the reference, later ones must match it
	function automatic void close_line();
		if (first_pending) begin
			ref_fields    = fcount;
			first_pending = 1'b0;
		end else if (fcount != ref_fields) begin
			err_st    = ST_MISMATCH;
			err_line  = line_no;
			err_found = fcount;
		end
	endfunction

	function automatic void scan_byte(input logic [7:0] b);
		// lf right after a line-closing cr is swallowed
		if (ph == PH_AFTER_CR) begin
			ph = PH_START;
			if (b == CH_LF)
				return;
		end
		// leading blanks and blank lines
		if (ph != PH_IN_LINE) begin
			if (b == CH_SPACE || b == CH_TAB || b == CH_CR)
				return;
			if (b == CH_LF) begin
				line_no = line_no + 1;
				return;
			end
			ph          = PH_IN_LINE;
			fcount      = '0;
			has_content = 1'b0;
			last_comma  = 1'b0;
		end
		if (b == CH_COMMA) begin
			bump_field();
			has_content = 1'b0;
			last_comma  = 1'b1;
		end else if (b == CH_LF || b == CH_CR) begin
			bump_field();
			has_content = 1'b0;
			last_comma  = 1'b0;
			line_no     = line_no + 1;
			ph          = (b == CH_CR) ? PH_AFTER_CR : PH_START;
			close_line();
		end else if (b == CH_NUL) begin
			err_st   = ST_NUL;
			err_line = line_no;
		end else begin
			has_content = 1'b1;
			last_comma  = 1'b0;
		end
	endfunction

	// advance the shadow by one accepted byte, queue a verdict on end of file
	function automatic void predict_byte(input logic [7:0] b, input logic last);
		verdict_t v;
		if (err_st == ST_VALID) begin
			scan_byte(b);
			if (last && err_st == ST_VALID && ph == PH_IN_LINE) begin
				if (has_content || last_comma)
					bump_field();
				close_line();
			end
		end
		if (last) begin
			v.st         = err_st;
			v.line       = (err_st != ST_VALID) ? err_line : 32'd0;
			v.exp_fields = ref_fields;
			v.found      = (err_st == ST_MISMATCH) ? err_found : '0;
			verdict_q.push_back(v);
			clear_shadow();
		end
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// send one byte request and wait for it to be taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		predict_byte(b, last);
		bytes_sent++;
	endtask

	// text as one file, end of file on its last character
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic send_buf();
		for (int i = 0; i < csv_buf.size(); i++)
			send_byte(csv_buf[i], i == csv_buf.size() - 1);
	endtask

	task automatic wait_all_verdicts();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// field content: any byte but the separators and nul
	function automatic logic [7:0] field_char();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		if (c == CH_COMMA || c == CH_LF || c == CH_CR)
			c = 8'h61;
		return c;
	endfunction

	// mostly well-formed file with random content into csv_buf
	function automatic void build_file();
		int cols;
		int lines;
		int n;
		int len;
		int r;
		csv_buf.delete();
		cols  = $urandom_range(1, 6);
		lines = $urandom_range(1, 6);
		for (int li = 0; li < lines; li++) begin
			// occasional blank line
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(0, 2)) begin
					r = $urandom_range(0, 2);
					csv_buf.push_back(r == 0 ? CH_SPACE : (r == 1 ? CH_TAB : CH_CR));
				end
				csv_buf.push_back(CH_LF);
			end
			n = cols;
			r = $urandom_range(0, 19);
			if (r == 0)
				n = cols + 1;
			else if (r == 1 && cols > 1)
				n = cols - 1;
			for (int f = 0; f < n; f++) begin
				if (f > 0)
					csv_buf.push_back(CH_COMMA);
				len = $urandom_range(0, 3);
				repeat (len)
					csv_buf.push_back(field_char());
				if ($urandom_range(0, 59) == 0)
					csv_buf.push_back(CH_NUL);
			end
			// line ending, the last line may stay open
			r = $urandom_range(0, 2);
			if (li == lines - 1 && $urandom_range(0, 2) == 0) begin
			end else if (r == 0) begin
				csv_buf.push_back(CH_LF);
			end else if (r == 1) begin
				csv_buf.push_back(CH_CR);
				csv_buf.push_back(CH_LF);
			end else begin
				csv_buf.push_back(CH_CR);
			end
		end
		if (csv_buf.size() == 0)
			csv_buf.push_back(field_char());
	endfunction

	// raw noise file
	function automatic void build_noise();
		csv_buf.delete();
		repeat ($urandom_range(1, 12))
			csv_buf.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic run_line_endings();
		// cr lf as one end, lone lf, lone cr
		send_text("a,b\015\012c,d\012e,f\015");
		// leading blanks and a blank line before the first line
		send_text(" \t\012\377,x\012");
	endtask

	task automatic run_blank_input();
		send_text(" \t\015\012");
		send_text("\012");
	endtask

	task automatic run_open_last_line();
		// trailing comma on the final byte counts one more field
		send_text("x,");
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic run_nul_bytes();
		send_byte(8'h61, 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(8'h62, 1'b1);
		// nul on the final byte itself
		send_byte(CH_NUL, 1'b1);
	endtask

	task automatic run_mismatch_latch();
		// line 2 is short, the later longer line is ignored
		send_text("a,b\012c\012d,e,f\012");
	endtask

	task automatic run_random_files();
		int files;
		int start;
		files = 0;
		start = bytes_sent;
		while (bytes_sent - start < RAND_BYTES) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			if (files % 10 == 9)
				wait_all_verdicts();
			if ($urandom_range(0, 99) < 85)
				build_file();
			else
				build_noise();
			send_buf();
			files++;
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// receiver with random stalls
	initial begin
		int rx_hold;
		rx_hold  = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (rx_hold != 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_calm)
					rx_hold = pick_gap();
			end
		end
	end

	// compare each verdict with the oldest prediction
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, got %h", $time, m_tdata);
				errors++;
			end else begin
				v = verdict_q.pop_front();
				if (m_tdata[1:0] !== v.st) begin
					$display("%0t: status expected %0d got %0d", $time, v.st, m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[33:2] !== v.line) begin
					$display("%0t: error_line expected %0d got %0d", $time, v.line,
						m_tdata[33:2]);
					errors++;
				end
				if (m_tdata[44:34] !== v.exp_fields) begin
					$display("%0t: expected_fields expected %0d got %0d", $time, v.exp_fields,
						m_tdata[44:34]);
					errors++;
				end
				if (m_tdata[55:45] !== v.found) begin
					$display("%0t: found_fields expected %0d got %0d", $time, v.found,
						m_tdata[55:45]);
					errors++;
				end
			end
		end
	end

	// cycles with no request taken on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// watchdog
	initial begin
		while (idle_cycles < STALL_MAX)
			@(posedge clk);
		$display("tb_top: done, errors");
		$finish;
	end

	// main sequence
	initial begin
		errors      = 0;
		bytes_sent  = 0;
		tx_calm     = 1'b0;
		rx_calm     = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		clear_shadow();
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_line_endings();
		run_blank_input();
		run_open_last_line();
		run_nul_bytes();
		run_mismatch_latch();
		run_random_files();

		wait_all_verdicts();
		repeat (DRAIN)
			@(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
